// File: src/prr_pkg.sv
`default_nettype none

package prr_pkg;

  // Field widths of the stream items.
  localparam int SeqW     = 16;
  localparam int HandleW  = 10;
  localparam int TimeW    = 32;
  localparam int CountW   = 16;
  localparam int KindW    = 2;
  localparam int Cnt8W    = 8;
  localparam int InDataW  = 64;
  localparam int OutDataW = 48;

  // Configuration port.
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;

  localparam logic [15:0] ResendGapReset    = 16'd250;
  localparam logic [7:0]  DropLimitReset    = 8'd15;
  localparam logic [15:0] GapLimitReset     = 16'd10;
  localparam logic [7:0]  TimeoutLimitReset = 8'd4;
  localparam logic [15:0] CountLimitReset   = 16'd2;

  typedef enum logic [KindW-1:0] {
    KIND_DELIVER = 2'd0,
    KIND_RESEND  = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_RESEND_GAP    = 3'd0,
    REG_DROP_LIMIT    = 3'd1,
    REG_GAP_LIMIT     = 3'd2,
    REG_TIMEOUT_LIMIT = 3'd3,
    REG_COUNT_LIMIT   = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_STORE,
    ST_RESEND,
    ST_SKIP_RD,
    ST_SKIP_CHK,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic [15:0] resend_gap_ms;
    logic [7:0]  drop_limit;
    logic [15:0] gap_limit;
    logic [7:0]  timeout_limit;
    logic [15:0] count_limit;
  } cfg_t;

  // Commands from the sequencer to the slot store.
  typedef struct packed {
    logic clear_all;
    logic wr_en;
    logic retire_en;
  } slot_cmd_t;

  // Registered view of one slot, valid the cycle after its read.
  typedef struct packed {
    logic               full;
    logic               done;
    logic [SeqW-1:0]    tag;
    logic [HandleW-1:0] handle;
  } slot_view_t;

  typedef struct packed {
    logic               out_of_window;
    logic               prefer_tcp;
    logic [HandleW-1:0] handle_out;
    logic [CountW-1:0]  resend_count;
    logic [SeqW-1:0]    seq_out;
    kind_e              kind;
  } result_t;

endpackage

`default_nettype wire

// File: src/prr_regs.sv
`default_nettype none

module prr_regs (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [prr_pkg::ApbAddrW-1:0]  paddr,
  input  wire  [prr_pkg::ApbDataW-1:0]  pwdata,
  output logic [prr_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output prr_pkg::cfg_t                 cfg_o
);
  import prr_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resend_gap_ms <= ResendGapReset;
      cfg_q.drop_limit    <= DropLimitReset;
      cfg_q.gap_limit     <= GapLimitReset;
      cfg_q.timeout_limit <= TimeoutLimitReset;
      cfg_q.count_limit   <= CountLimitReset;
    end else if (wr_en) begin
      case (idx)
        REG_RESEND_GAP:    cfg_q.resend_gap_ms <= pwdata[15:0];
        REG_DROP_LIMIT:    cfg_q.drop_limit    <= pwdata[7:0];
        REG_GAP_LIMIT:     cfg_q.gap_limit     <= pwdata[15:0];
        REG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= pwdata[7:0];
        REG_COUNT_LIMIT:   cfg_q.count_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESEND_GAP:    prdata = {16'd0, cfg_q.resend_gap_ms};
      REG_DROP_LIMIT:    prdata = {24'd0, cfg_q.drop_limit};
      REG_GAP_LIMIT:     prdata = {16'd0, cfg_q.gap_limit};
      REG_TIMEOUT_LIMIT: prdata = {24'd0, cfg_q.timeout_limit};
      REG_COUNT_LIMIT:   prdata = {16'd0, cfg_q.count_limit};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/prr_slots.sv
`default_nettype none

module prr_slots #(
  parameter int W = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  prr_pkg::slot_cmd_t            cmd_i,
  input  wire  [$clog2(W)-1:0]          act_idx_i,
  input  wire  [prr_pkg::SeqW-1:0]      wr_tag_i,
  input  wire  [prr_pkg::HandleW-1:0]   wr_handle_i,
  input  wire  [$clog2(W)-1:0]          rd_idx_i,
  output prr_pkg::slot_view_t           view_o
);
  import prr_pkg::*;

  logic [SeqW-1:0]    tag_mem    [W];
  logic [HandleW-1:0] handle_mem [W];
  logic [W-1:0]       full_q;
  logic [W-1:0]       done_q;
  logic               rd_full_q;
  logic               rd_done_q;
  logic [SeqW-1:0]    rd_tag_q;
  logic [HandleW-1:0] rd_handle_q;

  // Tag and handle are plain memory; reads are registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      tag_mem[act_idx_i]    <= wr_tag_i;
      handle_mem[act_idx_i] <= wr_handle_i;
    end
    rd_tag_q    <= tag_mem[rd_idx_i];
    rd_handle_q <= handle_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q    <= '0;
      done_q    <= '0;
      rd_full_q <= 1'b0;
      rd_done_q <= 1'b0;
    end else begin
      if (cmd_i.clear_all) begin
        full_q <= '0;
        done_q <= '0;
      end else if (cmd_i.wr_en) begin
        full_q[act_idx_i] <= 1'b1;
        done_q[act_idx_i] <= 1'b0;
      end else if (cmd_i.retire_en) begin
        full_q[act_idx_i] <= 1'b0;
        done_q[act_idx_i] <= 1'b1;
      end
      rd_full_q <= full_q[rd_idx_i];
      rd_done_q <= done_q[rd_idx_i];
    end
  end

  assign view_o.full   = rd_full_q;
  assign view_o.done   = rd_done_q;
  assign view_o.tag    = rd_tag_q;
  assign view_o.handle = rd_handle_q;

endmodule

`default_nettype wire

// File: src/prr_ctrl.sv
`default_nettype none

module prr_ctrl #(
  parameter int W = 32
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [prr_pkg::SeqW-1:0]      in_seq_i,
  input  wire  [prr_pkg::HandleW-1:0]   in_handle_i,
  input  wire  [prr_pkg::TimeW-1:0]     in_now_i,
  input  prr_pkg::cfg_t                 cfg_i,
  output prr_pkg::slot_cmd_t            slot_cmd_o,
  output logic [$clog2(W)-1:0]          act_idx_o,
  output logic [$clog2(W)-1:0]          rd_idx_o,
  output logic [prr_pkg::SeqW-1:0]      wr_tag_o,
  output logic [prr_pkg::HandleW-1:0]   wr_handle_o,
  input  prr_pkg::slot_view_t           view_i,
  output logic                          emit_valid_o,
  output logic                          emit_last_o,
  output prr_pkg::result_t              emit_o,
  input  wire                           emit_ok_i
);
  import prr_pkg::*;

  localparam int IdxW  = $clog2(W);
  localparam int StepW = $clog2(W + 1);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(W - 1);
  localparam logic [IdxW:0]    WinIdx  = (IdxW + 1)'(W);
  localparam logic [StepW-1:0] StepMax = StepW'(W);
  localparam logic [SeqW-1:0]  WinSeq  = SeqW'(W);

  state_e state_q, state_d;

  logic [SeqW-1:0]    seq_q;
  logic [HandleW-1:0] handle_q;
  logic [TimeW-1:0]   now_q, now_d;
  logic [SeqW-1:0]    exp_q, exp_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic [Cnt8W-1:0]   drop_q, drop_d;
  logic [Cnt8W-1:0]   tmo_q, tmo_d;
  logic [TimeW-1:0]   last_ms_q, last_ms_d;
  logic               tcp_q, tcp_d;
  logic               gt_q, ge_q, inwin_q, time_ok_q;
  logic [SeqW-1:0]    gap_q;
  logic [IdxW-1:0]    si_q;
  logic               oow_q, oow_d;

  logic               accept;
  logic               restart;
  logic [SeqW-1:0]    diff;
  logic [IdxW:0]      slot_sum;
  logic [IdxW-1:0]    si;
  logic [TimeW-1:0]   elapsed;
  logic [Cnt8W-1:0]   drop_inc;
  logic [Cnt8W-1:0]   tmo_inc;
  logic               tmo_trip;
  logic               echo;
  logic               waiting;
  logic [IdxW-1:0]    idx_next;

  assign accept  = in_valid_i && (state_q == ST_IDLE);
  assign restart = accept && (in_seq_i == '0);

  // Window position of the arriving packet, from the ring index of the
  // expected sequence; only used where the offset is inside the window.
  assign diff     = seq_q - exp_q;
  assign slot_sum = {1'b0, idx_q} + {1'b0, diff[IdxW-1:0]};
  assign si       = (slot_sum >= WinIdx) ? IdxW'(slot_sum - WinIdx) : slot_sum[IdxW-1:0];
  assign elapsed  = now_q - last_ms_q;

  assign drop_inc = (drop_q == '1) ? drop_q : drop_q + Cnt8W'(1);
  assign tmo_inc  = (tmo_q == '1) ? tmo_q : tmo_q + Cnt8W'(1);
  assign tmo_trip = tmo_q > cfg_i.timeout_limit;
  assign echo     = (view_i.full || view_i.done) && (view_i.tag == seq_q);
  assign waiting  = view_i.full && (view_i.tag == exp_q);
  // The ring index follows the expected sequence, which wraps to zero.
  assign idx_next = ((idx_q == LastIdx) || (exp_q == '1)) ? '0 : idx_q + IdxW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK:      state_d = ST_STORE;
      ST_STORE: begin
        if (!gt_q) state_d = ST_DRAIN_RD;
        else if (tmo_trip) state_d = ST_SKIP_RD;
        else if (time_ok_q) state_d = ST_RESEND;
        else state_d = ST_STATUS;
      end
      ST_RESEND:    if (emit_ok_i) state_d = ST_STATUS;
      ST_SKIP_RD:   state_d = (steps_q == StepMax) ? ST_DRAIN_RD : ST_SKIP_CHK;
      ST_SKIP_CHK:  state_d = waiting ? ST_DRAIN_RD : ST_SKIP_RD;
      ST_DRAIN_RD:  state_d = (steps_q == StepMax) ? ST_STATUS : ST_DRAIN_CHK;
      ST_DRAIN_CHK: begin
        if (!waiting) state_d = ST_STATUS;
        else if (emit_ok_i) state_d = ST_DRAIN_RD;
      end
      ST_STATUS:    if (emit_ok_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == ST_IDLE);
    slot_cmd_o   = '0;
    act_idx_o    = si_q;
    rd_idx_o     = idx_q;
    wr_tag_o     = seq_q;
    wr_handle_o  = handle_q;
    emit_valid_o = 1'b0;
    emit_last_o  = 1'b0;
    emit_o       = '0;
    emit_o.kind  = KIND_STATUS;
    emit_o.seq_out    = exp_q;
    emit_o.prefer_tcp = tcp_q;

    now_d     = now_q;
    exp_d     = exp_q;
    idx_d     = idx_q;
    steps_d   = steps_q;
    drop_d    = drop_q;
    tmo_d     = tmo_q;
    last_ms_d = last_ms_q;
    tcp_d     = tcp_q;
    oow_d     = oow_q;

    case (state_q)
      ST_IDLE: begin
        now_d = in_now_i;
        if (restart) begin
          slot_cmd_o.clear_all = 1'b1;
          exp_d  = '0;
          idx_d  = '0;
          drop_d = '0;
        end
      end
      ST_LOOK: begin
        rd_idx_o = si;
      end
      ST_STORE: begin
        act_idx_o         = si_q;
        slot_cmd_o.wr_en  = ge_q && inwin_q && !echo;
        oow_d             = ge_q && !inwin_q;
        steps_d           = '0;
        if (gt_q) begin
          drop_d = drop_inc;
          if ((drop_inc > cfg_i.drop_limit) || (gap_q > cfg_i.gap_limit) || tmo_trip ||
              (gap_q > cfg_i.count_limit)) begin
            tcp_d = 1'b1;
          end
          if (!tmo_trip) begin
            tmo_d = tmo_inc;
            if (time_ok_q) last_ms_d = now_q;
          end
        end
      end
      ST_RESEND: begin
        emit_valid_o        = 1'b1;
        emit_o.kind         = KIND_RESEND;
        emit_o.resend_count = gap_q;
      end
      ST_SKIP_RD: begin
        // A skip that walked the whole window hands a fresh count to the drain.
        if (steps_q == StepMax) steps_d = '0;
      end
      ST_SKIP_CHK: begin
        if (waiting) begin
          steps_d = '0;
        end else begin
          exp_d   = exp_q + SeqW'(1);
          idx_d   = idx_next;
          steps_d = steps_q + StepW'(1);
        end
      end
      ST_DRAIN_CHK: begin
        act_idx_o = idx_q;
        if (waiting) begin
          emit_valid_o      = 1'b1;
          emit_o.kind       = KIND_DELIVER;
          emit_o.handle_out = view_i.handle;
          if (emit_ok_i) begin
            slot_cmd_o.retire_en = 1'b1;
            tmo_d   = '0;
            exp_d   = exp_q + SeqW'(1);
            idx_d   = idx_next;
            steps_d = steps_q + StepW'(1);
          end
        end
      end
      ST_STATUS: begin
        emit_valid_o         = 1'b1;
        emit_last_o          = 1'b1;
        emit_o.out_of_window = oow_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      exp_q     <= '0;
      idx_q     <= '0;
      steps_q   <= '0;
      drop_q    <= '0;
      tmo_q     <= '0;
      last_ms_q <= '0;
      tcp_q     <= 1'b0;
      oow_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      exp_q     <= exp_d;
      idx_q     <= idx_d;
      steps_q   <= steps_d;
      drop_q    <= drop_d;
      tmo_q     <= tmo_d;
      last_ms_q <= last_ms_d;
      tcp_q     <= tcp_d;
      oow_q     <= oow_d;
    end
  end

  // Item payload and the compare results of the look-up cycle.
  always_ff @(posedge clk_i) begin
    now_q <= now_d;
    if (accept) begin
      seq_q    <= in_seq_i;
      handle_q <= in_handle_i;
    end
    if (state_q == ST_LOOK) begin
      gt_q      <= seq_q > exp_q;
      ge_q      <= seq_q >= exp_q;
      inwin_q   <= diff < WinSeq;
      gap_q     <= diff;
      si_q      <= si;
      time_ok_q <= elapsed > {16'd0, cfg_i.resend_gap_ms};
    end
  end

endmodule

`default_nettype wire

// File: src/packet_reorder_with_resend.sv
// Sequence reorder buffer with resend requests.
// Input stream (s_axis_*): one item per arriving packet, carrying its
// sequence number, the handle of the buffer that holds it, and the current
// millisecond time. Sequence 0 restarts the session and empties the ring.
// Output stream (m_axis_*): for every input item, zero or more deliveries
// (kind 0, in sequence order) or one resend request (kind 1), and then one
// status item (kind 2) that carries tlast. Registers sit on an APB port, and
// the user must write them only while the block is idle; nothing enforces it.
// Flow: the block takes one item at a time. An item passes through accept,
// look-up and store, then a resend state if one is due, or a read state and
// a check state per ring slot examined while skipping or draining, and then
// status. A skip or drain that has walked the whole window ends in its read
// state instead of a last check. The slot memory has a single read port
// with registered data, which is why each slot needs both states.
// Reset clears the window, the counters, the slot flags and the prefer-TCP
// flag, and loads the register defaults. When the receiver stalls, the
// result sits in the output register and the sequencer waits in place.
`default_nettype none

module packet_reorder_with_resend #(
  parameter int WINDOW = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // seq[15:0], handle[25:16], now_ms[57:26], zero[63:58]
  input  wire  [prr_pkg::InDataW-1:0]    s_axis_tdata,
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // kind[1:0], seq_out[17:2], resend_count[33:18], handle_out[43:34],
  // prefer_tcp[44], out_of_window[45], zero[47:46]
  output logic [prr_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  output logic                           m_axis_tlast,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [prr_pkg::ApbAddrW-1:0]   paddr,
  input  wire  [prr_pkg::ApbDataW-1:0]   pwdata,
  output logic [prr_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);
  import prr_pkg::*;

  localparam int IdxW = $clog2(WINDOW);

  cfg_t               cfg;
  slot_cmd_t          slot_cmd;
  slot_view_t         view;
  logic [IdxW-1:0]    act_idx;
  logic [IdxW-1:0]    rd_idx;
  logic [SeqW-1:0]    wr_tag;
  logic [HandleW-1:0] wr_handle;
  logic               emit_valid;
  logic               emit_last;
  result_t            emit;
  logic               emit_ok;

  logic                out_valid_q;
  logic                out_last_q;
  logic [OutDataW-1:0] out_data_q;

  prr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prr_slots #(.W(WINDOW)) u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (slot_cmd),
    .act_idx_i   (act_idx),
    .wr_tag_i    (wr_tag),
    .wr_handle_i (wr_handle),
    .rd_idx_i    (rd_idx),
    .view_o      (view)
  );

  prr_ctrl #(.W(WINDOW)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_seq_i     (s_axis_tdata[15:0]),
    .in_handle_i  (s_axis_tdata[25:16]),
    .in_now_i     (s_axis_tdata[57:26]),
    .cfg_i        (cfg),
    .slot_cmd_o   (slot_cmd),
    .act_idx_o    (act_idx),
    .rd_idx_o     (rd_idx),
    .wr_tag_o     (wr_tag),
    .wr_handle_o  (wr_handle),
    .view_i       (view),
    .emit_valid_o (emit_valid),
    .emit_last_o  (emit_last),
    .emit_o       (emit),
    .emit_ok_i    (emit_ok)
  );

  // Output register: a new result may load when it is empty or the held one leaves.
  assign emit_ok = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ok) begin
      out_valid_q <= emit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ok && emit_valid) begin
      out_data_q <= {2'b00, emit};
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: src/prr_checker.sv
`default_nettype none

module prr_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          s_axis_tvalid,
  input wire                          s_axis_tready,
  input wire [prr_pkg::OutDataW-1:0]  m_axis_tdata,
  input wire                          m_axis_tvalid,
  input wire                          m_axis_tready,
  input wire                          m_axis_tlast
);
  import prr_pkg::*;

  // The status item, and only it, closes the results of one input item.
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == KIND_STATUS)
    else $error("tlast on a result that is not a status");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[1:0] != KIND_STATUS)
    else $error("status result without tlast");

  a_oow_on_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[45] |-> m_axis_tlast)
    else $error("out_of_window flag outside a status result");

  // One item is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind packet_reorder_with_resend prr_checker u_prr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// File: bench/packet_reorder_with_resend_test.sv
`default_nettype none

// Self-checking bench for the packet reorder buffer. A software copy of the
// reorder window runs beside the block. Every accepted packet item updates
// that copy, and the copy's results are queued. Each item that leaves the
// output stream is compared field by field with the oldest queued result.
module packet_reorder_with_resend_test;
  import prr_pkg::*;

  localparam int Window       = 32;
  // Up to 33 results of one item can be stalled by the receiver. The run
  // uses a small fraction of this limit.
  localparam int CycleLimit   = 400000;
  // About one worst-case item of quiet time after the last result.
  localparam int SettleCycles = 150;

  // One result item as the output stream carries it.
  typedef struct packed {
    kind_e        kind;
    logic [15:0]  seq_out;
    logic [15:0]  resend_count;
    logic [9:0]   handle_out;
    logic         prefer_tcp;
    logic         out_of_window;
    logic         last;
  } pkt_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ApbAddrW-1:0]   paddr = '0;
  logic [ApbDataW-1:0]   pwdata = '0;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  packet_reorder_with_resend dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Period of 4 time units.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle and stall rates, in percent, for the current phase.
  int          send_idle_pct = 12;
  int          recv_stall_pct = 45;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic [31:0] now_clock = '0;

  // Software copy of the registers and of the reorder window.
  cfg_t        limits;
  logic [15:0] next_seq;
  bit          slot_full [Window];
  bit          slot_done [Window];
  logic [15:0] slot_tag [Window];
  logic [9:0]  slot_handle [Window];
  int unsigned drop_cnt;
  int unsigned stall_cnt;
  logic [31:0] last_resend;
  bit          tcp_flag;

  // Results that the window copy has produced and the block still owes.
  pkt_result_t owed_results [$];

  function automatic void clear_slots();
    for (int i = 0; i < Window; i++) begin
      slot_full[i] = 1'b0;
      slot_done[i] = 1'b0;
      slot_tag[i] = '0;
      slot_handle[i] = '0;
    end
  endfunction

  function automatic bit packet_waiting(input logic [15:0] s);
    return slot_full[s % Window] && slot_tag[s % Window] == s;
  endfunction

  function automatic int unsigned sat_inc(input int unsigned v);
    return v < 255 ? v + 1 : 255;
  endfunction

  function automatic pkt_result_t make_result(input kind_e k, input logic [15:0] s,
                                              input logic [15:0] cnt, input logic [9:0] h,
                                              input logic oow, input logic lst);
    pkt_result_t r;
    r.kind = k;
    r.seq_out = s;
    r.resend_count = cnt;
    r.handle_out = h;
    r.prefer_tcp = 1'b0;
    r.out_of_window = oow;
    r.last = lst;
    return r;
  endfunction

  // Applies one accepted packet to the window copy and queues the results
  // it causes: deliveries or a resend request, then the status item.
  task automatic track_packet(input logic [15:0] sq, input logic [9:0] h,
                              input logic [31:0] stamp);
    pkt_result_t step_q [$];
    logic [15:0] gap;
    logic [31:0] elapsed;
    int          idx;
    int          n;
    bit          oow;
    bit          drain;
    oow = 1'b0;
    drain = 1'b1;

    // Sequence zero restarts the session: the ring empties and the drop
    // count starts over, but the prefer-TCP flag stays as it is.
    if (sq == 16'd0) begin
      next_seq = '0;
      clear_slots();
      drop_cnt = 0;
    end

    if (sq >= next_seq) begin
      if (sq - next_seq >= Window) begin
        oow = 1'b1;
      end else begin
        idx = sq % Window;
        // A copy of a packet that is still held or already delivered is an
        // echo and leaves the slot alone.
        if (!((slot_full[idx] || slot_done[idx]) && slot_tag[idx] == sq)) begin
          slot_full[idx] = 1'b1;
          slot_done[idx] = 1'b0;
          slot_tag[idx] = sq;
          slot_handle[idx] = h;
        end
      end
    end

    if (sq > next_seq) begin
      gap = sq - next_seq;
      drop_cnt = sat_inc(drop_cnt);
      if (drop_cnt > limits.drop_limit || gap > limits.gap_limit) tcp_flag = 1'b1;
      if (stall_cnt > limits.timeout_limit) begin
        // Too many stalled attempts: jump past empty slots, then drain.
        n = 0;
        while (n < Window && !packet_waiting(next_seq)) begin
          next_seq++;
          n++;
        end
        tcp_flag = 1'b1;
      end else begin
        elapsed = stamp - last_resend;
        if (elapsed > limits.resend_gap_ms) begin
          step_q.push_back(make_result(KIND_RESEND, next_seq, gap, '0, 1'b0, 1'b0));
          last_resend = stamp;
        end
        if (gap > limits.count_limit) tcp_flag = 1'b1;
        stall_cnt = sat_inc(stall_cnt);
        drain = 1'b0;
      end
    end

    if (drain) begin
      n = 0;
      while (n < Window && packet_waiting(next_seq)) begin
        idx = next_seq % Window;
        step_q.push_back(make_result(KIND_DELIVER, next_seq, '0, slot_handle[idx],
                                     1'b0, 1'b0));
        slot_full[idx] = 1'b0;
        slot_done[idx] = 1'b1;
        stall_cnt = 0;
        next_seq++;
        n++;
      end
    end

    step_q.push_back(make_result(KIND_STATUS, next_seq, '0, '0, oow, 1'b1));

    // The flag as it stands after the whole step goes into every result.
    foreach (step_q[k]) begin
      step_q[k].prefer_tcp = tcp_flag;
      owed_results.push_back(step_q[k]);
    end
  endtask

  // Presents one packet item, with a random gap before it, and waits for
  // the handshake. tvalid stays high into the next item when no gap falls.
  task automatic send_packet(input logic [15:0] sq, input logic [9:0] h,
                             input logic [31:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata <= {6'd0, stamp, h, sq};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    track_packet(sq, h, stamp);
  endtask

  // Holds the sender off until every owed result has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
  endtask

  // Setup, access, then idle with psel low, so that back-to-back
  // writes never touch psel twice in one step.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Called only with the block idle and nothing owed.
  task automatic load_limits(input cfg_t c);
    write_reg(REG_RESEND_GAP, {16'd0, c.resend_gap_ms});
    write_reg(REG_DROP_LIMIT, {24'd0, c.drop_limit});
    write_reg(REG_GAP_LIMIT, {16'd0, c.gap_limit});
    write_reg(REG_TIMEOUT_LIMIT, {24'd0, c.timeout_limit});
    write_reg(REG_COUNT_LIMIT, {16'd0, c.count_limit});
    limits = c;
  endtask

  // In-order delivery, a resend for a one-packet gap, an echo of a held
  // packet, a fill that drains two packets, and late packets. The registers
  // still hold their reset values here.
  task automatic test_delivery_order();
    send_packet(16'd0, 10'd0, 32'd0);
    send_packet(16'd1, 10'd1023, 32'd5);
    send_packet(16'd2, 10'd512, 32'd6);
    send_packet(16'd4, 10'd33, 32'd300);
    send_packet(16'd4, 10'd34, 32'd301);
    send_packet(16'd3, 10'd35, 32'd302);
    send_packet(16'd4, 10'd36, 32'd303);
    send_packet(16'd2, 10'd37, 32'd304);
  endtask

  // A run of gaps: the first falls inside the resend hold-off, the second
  // asks again, and once the stall count passes its limit the window skips
  // the empty slots and drains what was held.
  task automatic test_resend_and_skip();
    send_packet(16'd7, 10'd100, 32'd310);
    send_packet(16'd8, 10'd101, 32'd600);
    send_packet(16'd9, 10'd102, 32'd601);
    send_packet(16'd10, 10'd103, 32'd602);
    send_packet(16'd11, 10'd104, 32'd603);
    send_packet(16'd13, 10'd105, 32'd604);
    send_packet(16'd12, 10'd106, 32'd605);
  endtask

  // Packets at and just inside the window edge, the largest sequence, time
  // at its top and wrapping past zero, and a restart with packets held.
  task automatic test_window_and_time_edges();
    send_packet(next_seq + 16'(Window), 10'd200, 32'hFFFF_FFF0);
    send_packet(next_seq + 16'(Window - 1), 10'd201, 32'hFFFF_FFFF);
    send_packet(16'hFFFF, 10'h3FF, 32'h0000_0010);
    send_packet(16'd0, 10'h155, 32'h0000_0400);
    send_packet(16'h5555, 10'h2AA, 32'hAAAA_5555);
  endtask

  // Random traffic shaped around the expected sequence, so that most
  // packets land in the window and keep the drain and skip paths busy.
  task automatic test_random_traffic(input int items, input int send_pct,
                                     input int recv_pct);
    int          pick;
    logic [15:0] sq;
    logic [15:0] recent;
    recent = next_seq;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) sq = next_seq + 16'($urandom_range(0, 3));
      else if (pick < 65) sq = next_seq + 16'($urandom_range(1, Window - 1));
      else if (pick < 75) sq = recent;
      else if (pick < 82) sq = next_seq - 16'($urandom_range(1, 8));
      else if (pick < 90) sq = next_seq + 16'($urandom_range(Window, Window + 16));
      else if (pick < 96) sq = 16'($urandom);
      else sq = 16'd0;

      // Mostly small steps of time; now and then a far jump or a step back.
      pick = $urandom_range(99);
      if (pick < 4) now_clock += $urandom;
      else if (pick < 7) now_clock -= $urandom_range(1, 1000);
      else now_clock += $urandom_range(0, 300);

      send_packet(sq, 10'($urandom_range(0, 1023)), now_clock);
      recent = sq;
      // Let the output run dry now and then with the sender held off.
      if (n % 40 == 39) wait_for_results();
    end
    wait_for_results();
  endtask

  // Every limit at zero: any gap prefers TCP and one stall starts skipping.
  task automatic test_random_low_limits();
    load_limits('{resend_gap_ms: 16'd0, drop_limit: 8'd0, gap_limit: 16'd0,
                  timeout_limit: 8'd0, count_limit: 16'd0});
    test_random_traffic(110, 12, 45);
  endtask

  // Every limit at its top: resends need long silences, skipping is rare.
  task automatic test_random_high_limits();
    load_limits('{resend_gap_ms: 16'hFFFF, drop_limit: 8'hFF, gap_limit: 16'hFFFF,
                  timeout_limit: 8'hFF, count_limit: 16'hFFFF});
    test_random_traffic(110, 45, 12);
  endtask

  // Random moderate limits with the stream running flat out.
  task automatic test_random_mixed_limits();
    cfg_t c;
    c.resend_gap_ms = 16'($urandom_range(0, 400));
    c.drop_limit = 8'($urandom_range(0, 40));
    c.gap_limit = 16'($urandom_range(0, 40));
    c.timeout_limit = 8'($urandom_range(0, 6));
    c.count_limit = 16'($urandom_range(0, 40));
    load_limits(c);
    test_random_traffic(110, 0, 0);
  endtask

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compares each accepted result item with the oldest owed result.
  always @(posedge clk_i) begin : check_results
    pkt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $error("result item with no expected result waiting");
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("kind", want.kind, m_axis_tdata[1:0]);
        check_field("seq_out", want.seq_out, m_axis_tdata[17:2]);
        check_field("resend_count", want.resend_count, m_axis_tdata[33:18]);
        check_field("handle_out", want.handle_out, m_axis_tdata[43:34]);
        check_field("prefer_tcp", want.prefer_tcp, m_axis_tdata[44]);
        check_field("out_of_window", want.out_of_window, m_axis_tdata[45]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    limits = '{resend_gap_ms: ResendGapReset, drop_limit: DropLimitReset,
               gap_limit: GapLimitReset, timeout_limit: TimeoutLimitReset,
               count_limit: CountLimitReset};
    next_seq = '0;
    clear_slots();
    drop_cnt = 0;
    stall_cnt = 0;
    last_resend = '0;
    tcp_flag = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_delivery_order();
    test_resend_and_skip();
    test_window_and_time_edges();
    wait_for_results();
    test_random_low_limits();
    test_random_high_limits();
    test_random_mixed_limits();

    // Quiet time after the last result, so that a stray item would show.
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
